/* src/rpt_pkg.sv */
// Package for the register producer table: shared constants, request codes,
// state type, control struct and lane status struct. No dependencies.
`timescale 1ns / 1ps

package rpt_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_REGS_DEF    = 256;
    localparam int MAX_SOURCES_DEF = 4;
    localparam int MAX_DESTS_DEF   = 2;
    localparam int SEQ_BITS_DEF    = 48;

    // Fixed field widths and field counts of the request and result.
    localparam int REG_W      = 8;
    localparam int SEQ_W      = 48;
    localparam int SRC_FIELDS = 4;
    localparam int DST_FIELDS = 2;

    // Request type codes. Code 3 has no meaning and returns an empty result.
    localparam logic [1:0] REQ_UOP   = 2'd0;
    localparam logic [1:0] REQ_PEEK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WR_DST1
    } t_state;

    // What one lane found for its source register.
    typedef struct packed {
        logic hit;    // valid producer at or above the oldest live number
        logic stale;  // valid producer that has retired
    } t_lane_flags;

    // Controls decoded from the sequencer state.
    typedef struct packed {
        logic busy;
        logic eval;
        logic wr_dst1;
    } t_ctrl;

endpackage

/* src/rpt_lane.sv */
// One source lane of the register producer table: a private copy of the
// sequence-number memory, its read register and the liveness compare.
// Depends on rpt_pkg.
`timescale 1ns / 1ps

module rpt_lane
    import rpt_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF,
    parameter int SEQ_BITS = SEQ_BITS_DEF,
    parameter int IDX_W    = $clog2(NUM_REGS)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic                i_use,
    input  logic [REG_W-1:0]    i_reg,
    input  logic [NUM_REGS-1:0] i_pvalid,
    input  logic [SEQ_BITS-1:0] i_oldest,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_idx,
    input  logic [SEQ_BITS-1:0] i_wr_seq,
    output t_lane_flags         o_flags,
    output logic [IDX_W-1:0]    o_idx,
    output logic [SEQ_BITS-1:0] o_seq
);

    logic [SEQ_BITS-1:0] r_mem [0:NUM_REGS-1];
    logic [SEQ_BITS-1:0] r_rd_seq;
    logic                r_active;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    rd_idx;
    logic                in_range;
    logic                live;

    assign rd_idx   = IDX_W'({{IDX_W{1'b0}}, i_reg});
    assign in_range = ({{(32-REG_W){1'b0}}, i_reg} < 32'(NUM_REGS));

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_seq;
        end
    end

    // The valid bit is sampled with the read; nothing changes it before
    // the compare in the following cycle.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_seq <= r_mem[rd_idx];
            r_active <= i_use && in_range && i_pvalid[rd_idx];
            r_idx    <= rd_idx;
        end
    end

    assign live          = r_active && (r_rd_seq >= i_oldest);
    assign o_flags.hit   = live;
    assign o_flags.stale = r_active && !live;
    assign o_idx         = r_idx;
    assign o_seq         = r_rd_seq;

endmodule

/* src/register_producer_table.sv */
// Top level of the register producer table: request capture, sequencer,
// valid bits, source lanes and the merge into the result registers.
// Depends on rpt_pkg and rpt_lane.
//
//  Channel   | Handshake                 | Payload
//  ----------+---------------------------+--------------------------------------
//  request   | start in, busy out        | i_req_type .. i_oldest_live
//  result    | o_done out, one cycle     | o_dep_valid_0..3, o_dep_seq_0..3
//
// A request is taken when start is high and busy is low. The lane memories
// are read as the request is taken; S_EVAL compares and writes the first
// destination, and S_WR_DST1, entered only for a micro-op with two
// destinations, writes the second over the single write port of each memory.
// The result strobe o_done rises in the cycle after the compare. Synchronous
// active-low reset clears the sequencer, the valid bits and the strobe; it
// needs no clearing pass. The receiver cannot stall the result.
`timescale 1ns / 1ps

module register_producer_table
    import rpt_pkg::*;
#(
    parameter int NUM_REGS    = NUM_REGS_DEF,
    parameter int MAX_SOURCES = MAX_SOURCES_DEF,
    parameter int MAX_DESTS   = MAX_DESTS_DEF,
    parameter int SEQ_BITS    = SEQ_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_req_type,
    input  logic [2:0]       i_src_count,
    input  logic [REG_W-1:0] i_src_reg_0,
    input  logic [REG_W-1:0] i_src_reg_1,
    input  logic [REG_W-1:0] i_src_reg_2,
    input  logic [REG_W-1:0] i_src_reg_3,
    input  logic [1:0]       i_dst_count,
    input  logic [REG_W-1:0] i_dst_reg_0,
    input  logic [REG_W-1:0] i_dst_reg_1,
    input  logic [SEQ_W-1:0] i_op_seq,
    input  logic [SEQ_W-1:0] i_oldest_live,
    output logic             o_done,
    output logic             o_dep_valid_0,
    output logic [SEQ_W-1:0] o_dep_seq_0,
    output logic             o_dep_valid_1,
    output logic [SEQ_W-1:0] o_dep_seq_1,
    output logic             o_dep_valid_2,
    output logic [SEQ_W-1:0] o_dep_seq_2,
    output logic             o_dep_valid_3,
    output logic [SEQ_W-1:0] o_dep_seq_3
);

    localparam int IDX_W     = $clog2(NUM_REGS);
    localparam int NUM_LANES = (MAX_SOURCES < SRC_FIELDS) ? MAX_SOURCES : SRC_FIELDS;
    localparam int NDST      = (MAX_DESTS < DST_FIELDS) ? MAX_DESTS : DST_FIELDS;
    localparam int DST_HI    = NDST - 1;

    t_state                r_state, n_state;
    t_ctrl                 ctrl;
    logic                  accept;

    logic [1:0]            r_req;
    logic [NDST-1:0]       r_dst_use;
    logic [IDX_W-1:0]      r_dst_idx [0:NDST-1];
    logic [SEQ_BITS-1:0]   r_op_seq;
    logic [SEQ_BITS-1:0]   r_oldest;
    logic [NUM_REGS-1:0]   r_pvalid, n_pvalid;

    logic                  r_done;
    logic [SRC_FIELDS-1:0] r_dep_valid;
    logic [SEQ_W-1:0]      r_dep_seq [0:SRC_FIELDS-1];

    logic [REG_W-1:0]      src_reg [0:SRC_FIELDS-1];
    logic [REG_W-1:0]      dst_reg [0:DST_FIELDS-1];
    t_lane_flags           flags   [0:SRC_FIELDS-1];
    logic [IDX_W-1:0]      lane_idx[0:SRC_FIELDS-1];
    logic [SEQ_BITS-1:0]   lane_seq[0:SRC_FIELDS-1];

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;

    assign accept = start && !busy;

    assign src_reg[0] = i_src_reg_0;
    assign src_reg[1] = i_src_reg_1;
    assign src_reg[2] = i_src_reg_2;
    assign src_reg[3] = i_src_reg_3;
    assign dst_reg[0] = i_dst_reg_0;
    assign dst_reg[1] = i_dst_reg_1;

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_req == REQ_UOP && (NDST > 1) && r_dst_use[DST_HI]) begin
                    n_state = S_WR_DST1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WR_DST1: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (r_state)
            S_IDLE:    ctrl = '0;
            S_EVAL:    ctrl = '{busy: 1'b1, eval: 1'b1, wr_dst1: 1'b0};
            S_WR_DST1: ctrl = '{busy: 1'b1, eval: 1'b0, wr_dst1: 1'b1};
            default:   ctrl = '0;
        endcase
    end

    assign busy = ctrl.busy;

    // ---------------------------------------------------------- request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req_type;
            r_op_seq <= SEQ_BITS'({{SEQ_BITS{1'b0}}, i_op_seq});
            r_oldest <= SEQ_BITS'({{SEQ_BITS{1'b0}}, i_oldest_live});
            for (int k = 0; k < NDST; k++) begin
                r_dst_use[k] <= (i_req_type == REQ_UOP) && (i_dst_count > 2'(k))
                    && ({{(32-REG_W){1'b0}}, dst_reg[k]} < 32'(NUM_REGS));
                r_dst_idx[k] <= IDX_W'({{IDX_W{1'b0}}, dst_reg[k]});
            end
        end
    end

    // -------------------------------------------------------------------- lanes
    assign wr_en  = (ctrl.eval && r_req == REQ_UOP && r_dst_use[0]) || ctrl.wr_dst1;
    assign wr_idx = ctrl.wr_dst1 ? r_dst_idx[DST_HI] : r_dst_idx[0];

    for (genvar g = 0; g < SRC_FIELDS; g++) begin : g_lane
        if (g < NUM_LANES) begin : g_on
            logic use_src;

            // Lane 0 also serves a peek.
            assign use_src = ((i_req_type == REQ_UOP) && (i_src_count > 3'(g)))
                || ((g == 0) && (i_req_type == REQ_PEEK) && (i_src_count != 3'd0));

            rpt_lane #(
                .NUM_REGS (NUM_REGS),
                .SEQ_BITS (SEQ_BITS),
                .IDX_W    (IDX_W)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rd_en  (accept),
                .i_use    (use_src),
                .i_reg    (src_reg[g]),
                .i_pvalid (r_pvalid),
                .i_oldest (r_oldest),
                .i_wr_en  (wr_en),
                .i_wr_idx (wr_idx),
                .i_wr_seq (r_op_seq),
                .o_flags  (flags[g]),
                .o_idx    (lane_idx[g]),
                .o_seq    (lane_seq[g])
            );
        end else begin : g_off
            assign flags[g]    = '0;
            assign lane_idx[g] = '0;
            assign lane_seq[g] = '0;
        end
    end

    // --------------------------------------------------------------- valid bits
    // Retired producers found by the lanes are dropped first; the destination
    // write of the same micro-op then wins on a shared register.
    always_comb begin
        n_pvalid = r_pvalid;
        if (ctrl.eval) begin
            case (r_req)
                REQ_CLEAR: n_pvalid = '0;
                REQ_UOP: begin
                    for (int i = 0; i < SRC_FIELDS; i++) begin
                        if (flags[i].stale) begin
                            n_pvalid[lane_idx[i]] = 1'b0;
                        end
                    end
                    if (r_dst_use[0]) begin
                        n_pvalid[r_dst_idx[0]] = 1'b1;
                    end
                end
                default: n_pvalid = r_pvalid;
            endcase
        end
        if (ctrl.wr_dst1) begin
            n_pvalid[r_dst_idx[DST_HI]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
        end else begin
            r_pvalid <= n_pvalid;
        end
    end

    // -------------------------------------------------------------------- merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ctrl.eval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.eval) begin
            for (int i = 0; i < SRC_FIELDS; i++) begin
                r_dep_valid[i] <= flags[i].hit;
                r_dep_seq[i]   <= flags[i].hit ? SEQ_W'({{SEQ_W{1'b0}}, lane_seq[i]})
                                               : '0;
            end
        end
    end

    assign o_done        = r_done;
    assign o_dep_valid_0 = r_dep_valid[0];
    assign o_dep_seq_0   = r_dep_seq[0];
    assign o_dep_valid_1 = r_dep_valid[1];
    assign o_dep_seq_1   = r_dep_seq[1];
    assign o_dep_valid_2 = r_dep_valid[2];
    assign o_dep_seq_2   = r_dep_seq[2];
    assign o_dep_valid_3 = r_dep_valid[3];
    assign o_dep_seq_3   = r_dep_seq[3];

endmodule

/* src/rpt_checker.sv */
// Port-level checks for the register producer table, attached by a bind.
// Depends on rpt_pkg and the register_producer_table ports.
`timescale 1ns / 1ps

module rpt_checker
    import rpt_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input logic             o_dep_valid_0,
    input logic [SEQ_W-1:0] o_dep_seq_0,
    input logic             o_dep_valid_1,
    input logic [SEQ_W-1:0] o_dep_seq_1,
    input logic             o_dep_valid_2,
    input logic [SEQ_W-1:0] o_dep_seq_2,
    input logic             o_dep_valid_3,
    input logic [SEQ_W-1:0] o_dep_seq_3
);

    // A taken request makes the block busy in the next cycle.
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after a request was taken");

    // Every taken request is answered by the result strobe.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_done)
        else $error("result strobe missing two cycles after a request");

    // A result only follows a cycle of work.
    a_result_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in flight");

    // Two results never come back to back.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // A slot without a producer reports sequence number zero.
    a_empty_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !((!o_dep_valid_0 && o_dep_seq_0 != '0)
                  || (!o_dep_valid_1 && o_dep_seq_1 != '0)
                  || (!o_dep_valid_2 && o_dep_seq_2 != '0)
                  || (!o_dep_valid_3 && o_dep_seq_3 != '0)))
        else $error("nonzero sequence number in a slot without a producer");

endmodule

bind register_producer_table rpt_checker u_rpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_dep_valid_0 (o_dep_valid_0),
    .o_dep_seq_0   (o_dep_seq_0),
    .o_dep_valid_1 (o_dep_valid_1),
    .o_dep_seq_1   (o_dep_seq_1),
    .o_dep_valid_2 (o_dep_valid_2),
    .o_dep_seq_2   (o_dep_seq_2),
    .o_dep_valid_3 (o_dep_valid_3),
    .o_dep_seq_3   (o_dep_seq_3)
);
